[src/asl_pkg.sv]
// ----------------------------------------------------------------------------
// asl_pkg
// shared widths, types, constants and helpers of the angle slerp interpolator
// ----------------------------------------------------------------------------
package asl_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int XW = 34;
   localparam int PW = 52;
   localparam int HW = 36;

   typedef logic signed [XW-1:0] word_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [HW-1:0] hword_type;

   localparam hword_type Q_PI      = 36'sd843314857;
   localparam hword_type Q_HALF_PI = 36'sd421657428;
   localparam hword_type Q_TWO_PI  = 36'sd1686629713;
   localparam word_type  OMEGA_MIN = 34'sd3796282;
   localparam word_type  KINV      = 34'sd163008219;

   typedef struct packed {
      logic signed [31:0] ha;
      logic [16:0]        blend;
      logic               lin;
      hword_type          sine;
   } item_type;

   function automatic word_type atan_q(input int unsigned idx);
      logic signed [31:0] v;
      begin
         case (idx)
            0: v = 32'sd210828714;
            1: v = 32'sd124459457;
            2: v = 32'sd65760959;
            3: v = 32'sd33381290;
            4: v = 32'sd16755422;
            5: v = 32'sd8385879;
            6: v = 32'sd4193963;
            7: v = 32'sd2097109;
            8: v = 32'sd1048571;
            9: v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            default: v = 32'sd0;
         endcase
         return word_type'(v);
      end
   endfunction

   // divide by 2^16, round half away from zero
   function automatic prod_type rnd16(input prod_type v);
      prod_type s;
      begin
         s = v + prod_type'(32768) - prod_type'(v[PW-1]);
         return s >>> 16;
      end
   endfunction

endpackage

[src/asl_prep.sv]
// ----------------------------------------------------------------------------
// asl_prep
// half-angle difference, shorter-arc flip, branch select and rotation product
// ----------------------------------------------------------------------------
module asl_prep (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [15:0]      from_angle,
   input  logic signed [15:0]      to_angle,
   input  logic [16:0]             blend,
   output logic                    out_valid,
   output asl_pkg::item_type       out_item,
   output asl_pkg::word_type       out_z
);

   logic [4:0]              vld_ff;
   logic signed [31:0]      ha_ff [5];
   logic [16:0]             t_ff [5];
   logic signed [32:0]      d1_ff;
   asl_pkg::word_type       dw_ff, dw_in;
   asl_pkg::word_type       df_ff, df_in;
   logic                    lin_ff, lin_in;
   asl_pkg::prod_type       prod_ff;
   asl_pkg::word_type       z_ff [2];
   logic                    lin5_ff;
   asl_pkg::hword_type      sine_ff;
   logic signed [16:0]      diff;
   asl_pkg::hword_type      d1x, dfx;

   assign diff = 17'(to_angle) - 17'(from_angle);
   assign d1x  = asl_pkg::hword_type'(d1_ff);

   always_comb begin
      if (d1x > asl_pkg::Q_PI)
         dw_in = asl_pkg::word_type'(d1x - asl_pkg::Q_TWO_PI);
      else if (d1x <= -asl_pkg::Q_PI)
         dw_in = asl_pkg::word_type'(d1x + asl_pkg::Q_TWO_PI);
      else
         dw_in = asl_pkg::word_type'(d1x);
   end

   always_comb begin
      dfx = asl_pkg::hword_type'(dw_ff);
      if (dfx > asl_pkg::Q_HALF_PI)
         df_in = asl_pkg::word_type'(dfx - asl_pkg::Q_PI);
      else if (dfx < -asl_pkg::Q_HALF_PI)
         df_in = asl_pkg::word_type'(dfx + asl_pkg::Q_PI);
      else
         df_in = dw_ff;
   end

   assign lin_in = (df_ff <= asl_pkg::OMEGA_MIN) && (df_ff >= -asl_pkg::OMEGA_MIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ha_ff[0] <= {from_angle[15], from_angle, 15'b0};
         t_ff[0]  <= blend;
         d1_ff    <= {diff[16], diff, 15'b0};
         for (int i = 1; i < 5; i++) begin
            ha_ff[i] <= ha_ff[i-1];
            t_ff[i]  <= t_ff[i-1];
         end
         dw_ff   <= dw_in;
         df_ff   <= df_in;
         lin_ff  <= lin_in;
         prod_ff <= asl_pkg::prod_type'(df_ff) *
                    asl_pkg::prod_type'($signed({1'b0, t_ff[2]}));
         z_ff[0] <= lin_in ? df_ff : '0;
         z_ff[1] <= z_ff[0];
         lin5_ff <= lin_ff;
         sine_ff <= asl_pkg::hword_type'(asl_pkg::rnd16(prod_ff));
      end
   end

   assign out_valid      = vld_ff[4];
   assign out_item.ha    = ha_ff[4];
   assign out_item.blend = t_ff[4];
   assign out_item.lin   = lin5_ff;
   assign out_item.sine  = sine_ff;
   assign out_z          = z_ff[1];

   a_arc_short: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (df_ff <= asl_pkg::word_type'(asl_pkg::Q_HALF_PI) &&
                     df_ff >= -asl_pkg::word_type'(asl_pkg::Q_HALF_PI)))
      else $error("shorter-arc difference out of range");

   a_lin_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (lin_ff || z_ff[0] == '0))
      else $error("rotation angle not cleared on sine branch");

endmodule

[src/asl_rot.sv]
// ----------------------------------------------------------------------------
// asl_rot
// rotation-mode cordic pipeline, one iteration per register stage
// ----------------------------------------------------------------------------
module asl_rot (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  asl_pkg::item_type       in_item,
   input  asl_pkg::word_type       in_z,
   output logic                    out_valid,
   output asl_pkg::item_type       out_item,
   output asl_pkg::word_type       out_x,
   output asl_pkg::word_type       out_y
);

   localparam int N = asl_pkg::CORDIC_STAGES;

   logic [N-1:0]            vld_ff;
   asl_pkg::word_type       x_ff [N];
   asl_pkg::word_type       y_ff [N];
   asl_pkg::word_type       z_ff [N];
   asl_pkg::item_type       item_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_stage
      asl_pkg::word_type    xi, yi, zi;
      asl_pkg::item_type    ii;
      if (g == 0) begin : g_first
         assign xi = asl_pkg::KINV;
         assign yi = '0;
         assign zi = in_z;
         assign ii = in_item;
      end else begin : g_next
         assign xi = x_ff[g-1];
         assign yi = y_ff[g-1];
         assign zi = z_ff[g-1];
         assign ii = item_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!zi[asl_pkg::XW-1]) begin
               x_ff[g] <= xi - (yi >>> g);
               y_ff[g] <= yi + (xi >>> g);
               z_ff[g] <= zi - asl_pkg::atan_q(g);
            end else begin
               x_ff[g] <= xi + (yi >>> g);
               y_ff[g] <= yi - (xi >>> g);
               z_ff[g] <= zi + asl_pkg::atan_q(g);
            end
            item_ff[g] <= ii;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_item  = item_ff[N-1];
   assign out_x     = x_ff[N-1];
   assign out_y     = y_ff[N-1];

endmodule

[src/asl_blend.sv]
// ----------------------------------------------------------------------------
// asl_blend
// linear weights applied to the start and rotated half vectors
// ----------------------------------------------------------------------------
module asl_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  asl_pkg::item_type       in_item,
   input  asl_pkg::word_type       in_x,
   input  asl_pkg::word_type       in_y,
   output logic                    out_valid,
   output asl_pkg::item_type       out_item,
   output asl_pkg::word_type       out_x,
   output asl_pkg::word_type       out_y
);

   logic [2:0]              vld_ff;
   asl_pkg::item_type       item_ff [3];
   asl_pkg::prod_type       mx_ff, my_ff, sx_ff, sy_ff;
   logic signed [17:0]      omt_ff;
   asl_pkg::word_type       bx_ff, by_ff;
   asl_pkg::prod_type       tw;

   assign tw = asl_pkg::prod_type'($signed({1'b0, in_item.blend}));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff      <= tw * asl_pkg::prod_type'(in_x);
         my_ff      <= tw * asl_pkg::prod_type'(in_y);
         omt_ff     <= 18'sd65536 - $signed({1'b0, in_item.blend});
         item_ff[0] <= in_item;
         sx_ff      <= (asl_pkg::prod_type'(omt_ff) <<< 28) + mx_ff;
         sy_ff      <= my_ff;
         item_ff[1] <= item_ff[0];
         bx_ff      <= asl_pkg::word_type'(asl_pkg::rnd16(sx_ff));
         by_ff      <= asl_pkg::word_type'(asl_pkg::rnd16(sy_ff));
         item_ff[2] <= item_ff[1];
      end
   end

   assign out_valid = vld_ff[2];
   assign out_item  = item_ff[2];
   assign out_x     = bx_ff;
   assign out_y     = by_ff;

endmodule

[src/asl_vec.sv]
// ----------------------------------------------------------------------------
// asl_vec
// vectoring-mode cordic pipeline giving the angle of the blended vector
// ----------------------------------------------------------------------------
module asl_vec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  asl_pkg::item_type       in_item,
   input  asl_pkg::word_type       in_x,
   input  asl_pkg::word_type       in_y,
   output logic                    out_valid,
   output asl_pkg::item_type       out_item,
   output asl_pkg::word_type       out_angle
);

   localparam int N = asl_pkg::CORDIC_STAGES;

   logic [N-1:0]            vld_ff;
   asl_pkg::word_type       x_ff [N];
   asl_pkg::word_type       y_ff [N];
   asl_pkg::word_type       a_ff [N];
   asl_pkg::item_type       item_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_stage
      asl_pkg::word_type    xi, yi, ai;
      asl_pkg::item_type    ii;
      if (g == 0) begin : g_first
         assign xi = in_x;
         assign yi = in_y;
         assign ai = '0;
         assign ii = in_item;
      end else begin : g_next
         assign xi = x_ff[g-1];
         assign yi = y_ff[g-1];
         assign ai = a_ff[g-1];
         assign ii = item_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (yi[asl_pkg::XW-1]) begin
               x_ff[g] <= xi - (yi >>> g);
               y_ff[g] <= yi + (xi >>> g);
               a_ff[g] <= ai - asl_pkg::atan_q(g);
            end else begin
               x_ff[g] <= xi + (yi >>> g);
               y_ff[g] <= yi - (xi >>> g);
               a_ff[g] <= ai + asl_pkg::atan_q(g);
            end
            item_ff[g] <= ii;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_item  = item_ff[N-1];
   assign out_angle = a_ff[N-1];

endmodule

[src/angle_slerp_interpolator.sv]
// path: prep, rotation cordic, blend, vectoring cordic and output registers from req beat to rsp beat
// throughput: one beat per cycle while rsp is not stalled, set by the one-iteration-per-stage cordic pipes
// the whole pipe advances together; it holds while a result waits at rsp
// reset clears all stage valid flags; data registers are not reset
// ----------------------------------------------------------------------------
// angle_slerp_interpolator
// shortest-arc angle interpolation as a slerp of half-angle unit vectors
// ----------------------------------------------------------------------------
module angle_slerp_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // from_angle[15:0], to_angle[31:16], blend[48:32], zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata    // result_angle[15:0]
);

   logic                    en;
   logic                    p_vld, r_vld, b_vld, v_vld;
   asl_pkg::item_type       p_item, r_item, b_item, v_item;
   asl_pkg::word_type       p_z, r_x, r_y, b_x, b_y, v_a;
   logic [2:0]              vld_ff;
   asl_pkg::hword_type      h_ff, hw_ff, hw_in, hr;
   logic [15:0]             out_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   asl_prep u_prep (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .from_angle(req_tdata[15:0]), .to_angle(req_tdata[31:16]),
      .blend(req_tdata[48:32]),
      .out_valid(p_vld), .out_item(p_item), .out_z(p_z)
   );

   asl_rot u_rot (
      .clock(clock), .reset(reset), .en(en), .in_valid(p_vld),
      .in_item(p_item), .in_z(p_z),
      .out_valid(r_vld), .out_item(r_item), .out_x(r_x), .out_y(r_y)
   );

   asl_blend u_blend (
      .clock(clock), .reset(reset), .en(en), .in_valid(r_vld),
      .in_item(r_item), .in_x(r_x), .in_y(r_y),
      .out_valid(b_vld), .out_item(b_item), .out_x(b_x), .out_y(b_y)
   );

   asl_vec u_vec (
      .clock(clock), .reset(reset), .en(en), .in_valid(b_vld),
      .in_item(b_item), .in_x(b_x), .in_y(b_y),
      .out_valid(v_vld), .out_item(v_item), .out_angle(v_a)
   );

   always_comb begin
      if (h_ff > asl_pkg::Q_PI)
         hw_in = h_ff - asl_pkg::Q_TWO_PI;
      else if (h_ff <= -asl_pkg::Q_PI)
         hw_in = h_ff + asl_pkg::Q_TWO_PI;
      else
         hw_in = h_ff;
   end

   assign hr = (hw_ff + asl_pkg::hword_type'(16384)
                - asl_pkg::hword_type'(hw_ff[asl_pkg::HW-1])) >>> 15;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], v_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff   <= asl_pkg::hword_type'(v_item.ha) +
                   (v_item.lin ? asl_pkg::hword_type'(v_a) : v_item.sine);
         hw_ff  <= hw_in;
         out_ff <= hr[15:0];
      end
   end

   assign rsp_tvalid = vld_ff[2];
   assign rsp_tdata  = out_ff;

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds_in: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipe is stalled");

endmodule
